// ----- rtl/npcs_pkg.sv -----
// ----------------------------------------------------------------------------
// npcs_pkg
// shared types, constants and the distance function of the palette search
// ----------------------------------------------------------------------------
package npcs_pkg;

    localparam int PALETTE_ENTRIES = 256;

    localparam int IDX_W  = 8;
    localparam int CHAN_W = 8;
    localparam int CODE_W = 15;
    localparam int DIST_W = 18;
    localparam int RGB_W  = 3 * CHAN_W;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    localparam logic [0:0] MODE_WRITE = 1'b0;
    localparam logic [0:0] MODE_QUERY = 1'b1;

    // larger than any real distance, so the first entry always wins
    localparam logic [DIST_W-1:0] DIST_NONE = {DIST_W{1'b1}};

    typedef struct packed {
        logic              vld;
        logic              qry;
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  wr_idx;
        logic [RGB_W-1:0]  wr_rgb;
        logic [DIST_W-1:0] best;
        logic [IDX_W-1:0]  best_idx;
        logic [DIST_W-1:0] cand_dist;
        logic [IDX_W-1:0]  cand_idx;
    } stage_t;

    function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                    input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return (2*CHAN_W)'(d) * (2*CHAN_W)'(d);
    endfunction

    // code bits: red 0-4, green 5-9, blue 10-14, each expanded as c*8+4
    function automatic logic [DIST_W-1:0] color_dist(input logic [CODE_W-1:0] code,
                                                     input logic [RGB_W-1:0]  rgb);
        logic [CHAN_W-1:0] qr;
        logic [CHAN_W-1:0] qg;
        logic [CHAN_W-1:0] qb;
        qr = {code[4:0], 3'b100};
        qg = {code[9:5], 3'b100};
        qb = {code[14:10], 3'b100};
        return DIST_W'(sq_diff(qr, rgb[7:0]))
             + DIST_W'(sq_diff(qg, rgb[15:8]))
             + DIST_W'(sq_diff(qb, rgb[23:16]));
    endfunction

endpackage

// ----- rtl/npcs_cell.sv -----
// ----------------------------------------------------------------------------
// npcs_cell
// one systolic cell: holds a palette entry, folds in the previous distance
// and computes the distance of the passing query to its own entry
// ----------------------------------------------------------------------------
module npcs_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [npcs_pkg::IDX_W-1:0] cell_id,
    input  npcs_pkg::stage_t      prev,
    output npcs_pkg::stage_t      cur
);
    import npcs_pkg::*;

    logic [RGB_W-1:0] entry_reg;
    stage_t           stage_reg;
    stage_t           stage_next;
    logic             wr_hit;

    assign wr_hit = prev.vld && !prev.qry && (prev.wr_idx == cell_id);

    always_comb
    begin
        stage_next = prev;
        // strict compare keeps the lower index on ties
        if (prev.cand_dist < prev.best)
        begin
            stage_next.best     = prev.cand_dist;
            stage_next.best_idx = prev.cand_idx;
        end
        stage_next.cand_dist = color_dist(prev.code, entry_reg);
        stage_next.cand_idx  = cell_id;
    end

    always_ff @(posedge clk)
    begin
        if (en && wr_hit)
        begin
            entry_reg <= prev.wr_rgb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign cur = stage_reg;

endmodule

// ----- rtl/nearest_palette_color_search.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// nearest palette entry search for 15-bit color codes over a 256-entry palette
// ----------------------------------------------------------------------------
// A chain of PALETTE_ENTRIES cells, one per palette entry, followed by one
// output register. Every word (palette write or query) walks the chain one
// cell per cycle unless the output stalls, so a new word can be taken every
// such cycle; a query result leaves through the output register after the
// last cell. Writes update the entry as they pass its cell, so each query
// sees exactly the writes accepted before it. Writes give no result.
// A stall on the output side holds the whole chain.
module nearest_palette_color_search (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_index, entry_red, entry_green, entry_blue, color_code, zero pad
    input  logic [npcs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // mode
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // nearest_index, best_distance, queried_code, zero pad
    output logic [npcs_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import npcs_pkg::*;

    stage_t                  chain [PALETTE_ENTRIES+1];
    stage_t                  head;
    logic                    en;
    logic                    out_vld_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic [DIST_W-1:0]       out_dist_reg;
    logic [CODE_W-1:0]       out_code_reg;
    logic [IDX_W-1:0]        fin_idx;
    logic [DIST_W-1:0]       fin_dist;
    stage_t                  last;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        head.vld       = s_axis_tvalid;
        head.qry       = (s_axis_tuser == MODE_QUERY);
        head.wr_idx    = s_axis_tdata[7:0];
        head.wr_rgb    = s_axis_tdata[31:8];
        head.code      = s_axis_tdata[46:32];
        head.best      = DIST_NONE;
        head.best_idx  = '0;
        head.cand_dist = DIST_NONE;
        head.cand_idx  = '0;
    end

    assign chain[0] = head;

    for (genvar v = 0; v < PALETTE_ENTRIES; v++)
    begin : g_cell
        npcs_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .cell_id (IDX_W'(v)),
            .prev    (chain[v]),
            .cur     (chain[v+1])
        );
    end

    assign last = chain[PALETTE_ENTRIES];

    always_comb
    begin
        fin_idx  = last.best_idx;
        fin_dist = last.best;
        if (last.cand_dist < last.best)
        begin
            fin_idx  = last.cand_idx;
            fin_dist = last.cand_dist;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= last.vld && last.qry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_idx_reg  <= fin_idx;
            out_dist_reg <= fin_dist;
            out_code_reg <= last.code;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'd0, out_code_reg, out_dist_reg, out_idx_reg};

    a_ready_follows_out : assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not track output space");

    a_query_reaches_out : assert property (@(posedge clk) disable iff (!rst_n)
        en && last.vld && last.qry |=> m_axis_tvalid)
        else $error("query leaving the chain produced no result");

    a_dist_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_dist_reg <= DIST_W'(190512)))
        else $error("result distance beyond any real distance");

endmodule
